### hdl/catmull_rom_path_follower_core_defines.svh
// Assertion macros for the checker file of the path follower.
`ifndef CATMULL_ROM_PATH_FOLLOWER_CORE_DEFINES_SVH
`define CATMULL_ROM_PATH_FOLLOWER_CORE_DEFINES_SVH

// Concurrent assertion that is switched off while reset is high.
`define CRPF_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Concurrent assertion that is also checked during reset.
`define CRPF_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

### hdl/crpf_pkg.sv
`default_nettype none

package crpf_pkg;

  localparam int COORD_W    = 32;
  localparam int SEG_W      = 6;
  localparam int FRAC_W     = 17;
  localparam int FRAC_BITS  = 16;
  localparam int FRAMES_W   = 16;
  localparam int PCOUNT_W   = 7;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int LANES      = 3;

  // Horner intermediates stay below 2^38 in magnitude for 32-bit points.
  localparam int HORNER_W = 40;
  localparam int TMUL_W   = FRAC_W + 1;
  localparam int PROD_W   = HORNER_W + TMUL_W;
  localparam int FIN_W    = HORNER_W + 2;

  localparam int DIV_BITS  = 2;
  localparam int DIV_STEPS = FRAMES_W / DIV_BITS;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int TAPS      = 4;
  localparam int TAP_W     = $clog2(TAPS);

  localparam int MAX_POINTS_DEF = 64;
  localparam int TABLE_LIMIT    = 1 << SEG_W;

  localparam logic [FRAMES_W-1:0] FRAMES_RESET = FRAMES_W'(60);
  localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = PCOUNT_W'(4);
  localparam logic [PCOUNT_W-1:0] PCOUNT_MIN   = PCOUNT_W'(4);
  localparam logic [SEG_W-1:0]    SEG_RESET    = SEG_W'(1);
  localparam logic [FRAC_W-1:0]   T_ONE        = FRAC_W'(1 << FRAC_BITS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAMES_PER_SEGMENT = 1'b0,
    REG_POINT_COUNT        = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_COEF,
    ST_MUL,
    ST_ADD,
    ST_PUSH
  } state_t;

  // Coefficient folded in after each multiply by t, or none after the last.
  typedef enum logic [1:0] {
    TERM_B,
    TERM_A,
    TERM_NONE
  } term_t;

  typedef enum logic [1:0] {
    T_DIV,
    T_ZERO,
    T_FULL
  } tmode_t;

  typedef struct packed {
    logic             load_point;
    logic             tick_start;
    logic             div_step;
    logic             rd_en;
    logic [TAP_W-1:0] rd_off;
    logic             coef;
    logic             mul;
    logic             add;
    term_t            term;
    logic             push;
  } cmd_t;

endpackage

`default_nettype wire

### hdl/crpf_in_if.sv
`default_nettype none

interface crpf_in_if;
  import crpf_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [SEG_W-1:0]          point_index;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [COORD_W-1:0] point_z;

  modport source (
    output valid, action, point_index, point_x, point_y, point_z,
    input  ready
  );

  modport sink (
    input  valid, action, point_index, point_x, point_y, point_z,
    output ready
  );

endinterface

`default_nettype wire

### hdl/crpf_out_if.sv
`default_nettype none

interface crpf_out_if;
  import crpf_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [COORD_W-1:0] pos_z;
  logic [SEG_W-1:0]          segment;
  logic [FRAC_W-1:0]         fraction;
  logic                      at_end;

  modport source (
    output valid, pos_x, pos_y, pos_z, segment, fraction, at_end,
    input  ready
  );

  modport sink (
    input  valid, pos_x, pos_y, pos_z, segment, fraction, at_end,
    output ready
  );

endinterface

`default_nettype wire

### hdl/crpf_ctrl.sv
`default_nettype none

module crpf_ctrl (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire logic    in_action,
  input  wire logic    out_ready,
  output logic         in_ready,
  output logic         out_valid,
  output crpf_pkg::cmd_t cmd
);
  import crpf_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  term_t             term;
  term_t             term_next;
  logic              out_valid_next;
  logic              in_fire;
  logic              push_ok;

  assign in_fire = in_valid && in_ready;
  assign push_ok = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      term      <= TERM_B;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      term      <= term_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    term_next  = term;
    unique case (state)
      ST_IDLE: begin
        if (in_fire && in_action) begin
          state_next = ST_FETCH;
          step_next  = '0;
        end
      end
      ST_FETCH: begin
        step_next = step + 1'b1;
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = ST_COEF;
        end
      end
      ST_COEF: begin
        state_next = ST_MUL;
        term_next  = TERM_B;
      end
      ST_MUL: begin
        state_next = ST_ADD;
      end
      ST_ADD: begin
        unique case (term)
          TERM_B:  term_next = TERM_A;
          TERM_A:  term_next = TERM_NONE;
          default: term_next = TERM_B;
        endcase
        state_next = (term == TERM_NONE) ? ST_PUSH : ST_MUL;
      end
      ST_PUSH: begin
        if (push_ok) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    if (cmd.push) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_comb begin
    in_ready       = (state == ST_IDLE);
    cmd            = '0;
    cmd.load_point = in_fire && !in_action;
    cmd.tick_start = in_fire && in_action;
    cmd.div_step   = (state == ST_FETCH);
    cmd.rd_en      = (state == ST_FETCH) && (step < STEP_W'(TAPS));
    cmd.rd_off     = step[TAP_W-1:0];
    cmd.coef       = (state == ST_COEF);
    cmd.mul        = (state == ST_MUL);
    cmd.add        = (state == ST_ADD);
    cmd.term       = term;
    cmd.push       = (state == ST_PUSH) && push_ok;
  end

endmodule

`default_nettype wire

### hdl/crpf_datapath.sv
`default_nettype none

module crpf_datapath #(
  parameter int MAX_POINTS = crpf_pkg::MAX_POINTS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire crpf_pkg::cmd_t                      cmd,
  input  wire logic                                cfg_wr_en,
  input  wire logic [crpf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [crpf_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic [crpf_pkg::SEG_W-1:0]          point_index,
  input  wire logic signed [crpf_pkg::COORD_W-1:0] point_x,
  input  wire logic signed [crpf_pkg::COORD_W-1:0] point_y,
  input  wire logic signed [crpf_pkg::COORD_W-1:0] point_z,
  output logic signed [crpf_pkg::COORD_W-1:0]      pos_x,
  output logic signed [crpf_pkg::COORD_W-1:0]      pos_y,
  output logic signed [crpf_pkg::COORD_W-1:0]      pos_z,
  output logic [crpf_pkg::SEG_W-1:0]               segment,
  output logic [crpf_pkg::FRAC_W-1:0]              fraction,
  output logic                                     at_end
);
  import crpf_pkg::*;

  localparam int TABLE_DEPTH = (MAX_POINTS < TABLE_LIMIT) ? MAX_POINTS : TABLE_LIMIT;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int PC_CAP      = (1 << PCOUNT_W) - 1;
  localparam int PC_MAX      = (MAX_POINTS < PC_CAP) ? MAX_POINTS : PC_CAP;
  localparam int ROW_W       = LANES * COORD_W;

  // Configuration registers.
  logic [FRAMES_W-1:0] frames_per_segment;
  logic [PCOUNT_W-1:0] point_count;
  logic [FRAMES_W-1:0] frames_eff;
  logic [PCOUNT_W-1:0] pc_eff;

  // Path state.
  logic [SEG_W-1:0]    seg;
  logic [SEG_W-1:0]    seg_next;
  logic [FRAMES_W-1:0] frame_count;
  logic [FRAMES_W-1:0] frame_count_next;
  logic [FRAMES_W-1:0] frame_count_inc;
  tmode_t              tmode;
  tmode_t              tmode_next;
  logic                end_flag;
  logic                end_flag_next;
  logic                reached;
  logic                can_adv;

  // Divider.
  logic [FRAMES_W:0]   div_rem;
  logic [FRAMES_W:0]   div_rem_next;
  logic [FRAMES_W:0]   div_dbl;
  logic [FRAMES_W-1:0] div_quot;
  logic [FRAMES_W-1:0] div_quot_next;
  logic [FRAC_W-1:0]   t_val;
  logic signed [TMUL_W-1:0] t_mul;

  // Point memory and tap line.
  logic [ROW_W-1:0]    point_mem [TABLE_DEPTH];
  logic [ROW_W-1:0]    mem_q;
  logic                rd_pending;
  logic [ROW_W-1:0]    tap [TAPS];
  logic [PCOUNT_W-1:0] last_pt;
  logic                clamp;
  logic [SEG_W-1:0]    rd_addr;
  logic                wr_ok;

  logic signed [COORD_W-1:0] lane_res [LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_per_segment <= FRAMES_RESET;
      point_count        <= PCOUNT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAMES_PER_SEGMENT: frames_per_segment <= cfg_data;
        REG_POINT_COUNT:        point_count <= cfg_data[PCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign frames_eff = (frames_per_segment == '0) ? FRAMES_W'(1) : frames_per_segment;

  always_comb begin
    if (point_count < PCOUNT_MIN) begin
      pc_eff = PCOUNT_MIN;
    end else if (point_count > PCOUNT_W'(PC_MAX)) begin
      pc_eff = PCOUNT_W'(PC_MAX);
    end else begin
      pc_eff = point_count;
    end
  end

  // The fraction comes from the count before its increment.
  assign frame_count_inc = (frame_count != '1) ? frame_count + 1'b1 : frame_count;
  assign reached         = (frame_count >= frames_eff);
  assign can_adv         = (PCOUNT_W'(seg) + PCOUNT_W'(3)) < pc_eff;

  always_comb begin
    seg_next         = seg;
    frame_count_next = frame_count_inc;
    tmode_next       = T_DIV;
    end_flag_next    = 1'b0;
    if (reached && can_adv) begin
      seg_next         = seg + 1'b1;
      frame_count_next = '0;
      tmode_next       = T_ZERO;
    end else if (reached) begin
      tmode_next    = T_FULL;
      end_flag_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg         <= SEG_RESET;
      frame_count <= '0;
      rd_pending  <= 1'b0;
    end else begin
      if (cmd.tick_start) begin
        seg         <= seg_next;
        frame_count <= frame_count_next;
      end
      rd_pending <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_start) begin
      tmode    <= tmode_next;
      end_flag <= end_flag_next;
    end
  end

  // Restoring division of count * 2^16 by the frames per segment, two quotient bits a beat.
  always_comb begin
    div_rem_next  = div_rem;
    div_quot_next = div_quot;
    div_dbl       = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      div_dbl = {div_rem_next[FRAMES_W-1:0], 1'b0};
      if (div_dbl >= {1'b0, frames_eff}) begin
        div_rem_next  = div_dbl - {1'b0, frames_eff};
        div_quot_next = {div_quot_next[FRAMES_W-2:0], 1'b1};
      end else begin
        div_rem_next  = div_dbl;
        div_quot_next = {div_quot_next[FRAMES_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_start) begin
      div_rem  <= {1'b0, frame_count};
      div_quot <= '0;
    end else if (cmd.div_step) begin
      div_rem  <= div_rem_next;
      div_quot <= div_quot_next;
    end
  end

  always_comb begin
    unique case (tmode)
      T_DIV:   t_val = {1'b0, div_quot};
      T_ZERO:  t_val = '0;
      T_FULL:  t_val = T_ONE;
      default: t_val = '0;
    endcase
  end

  assign t_mul = signed'({1'b0, t_val});

  // Beyond the last segment all four taps read the clamp point, so the cubic reduces to it.
  assign last_pt = pc_eff - PCOUNT_W'(2);
  assign clamp   = PCOUNT_W'(seg) > last_pt;
  assign rd_addr = clamp ? last_pt[SEG_W-1:0] : seg + SEG_W'(cmd.rd_off) - SEG_W'(1);
  assign wr_ok   = {1'b0, point_index} < (SEG_W + 1)'(TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (cmd.load_point && wr_ok) begin
      point_mem[point_index[ADDR_W-1:0]] <= {point_z, point_y, point_x};
    end
    if (cmd.rd_en) begin
      mem_q <= point_mem[rd_addr[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pending) begin
      for (int k = 0; k < TAPS - 1; k++) begin
        tap[k] <= tap[k + 1];
      end
      tap[TAPS-1] <= mem_q;
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic signed [HORNER_W-1:0] p0;
    logic signed [HORNER_W-1:0] p1;
    logic signed [HORNER_W-1:0] p2;
    logic signed [HORNER_W-1:0] p3;
    logic signed [HORNER_W-1:0] coef_a;
    logic signed [HORNER_W-1:0] coef_b;
    logic signed [HORNER_W-1:0] coef_c;
    logic signed [HORNER_W-1:0] ka;
    logic signed [HORNER_W-1:0] kb;
    logic signed [HORNER_W-1:0] acc;
    logic signed [PROD_W-1:0]   prod;
    logic signed [PROD_W-1:0]   prod_rnd;
    logic signed [HORNER_W-1:0] h_scaled;
    logic signed [HORNER_W-1:0] addend;
    logic signed [FIN_W-1:0]    fin_sum;
    logic signed [FIN_W-1:0]    fin_half;
    logic signed [COORD_W-1:0]  fin_sat;

    assign p0 = HORNER_W'(signed'(tap[0][l*COORD_W +: COORD_W]));
    assign p1 = HORNER_W'(signed'(tap[1][l*COORD_W +: COORD_W]));
    assign p2 = HORNER_W'(signed'(tap[2][l*COORD_W +: COORD_W]));
    assign p3 = HORNER_W'(signed'(tap[3][l*COORD_W +: COORD_W]));

    assign coef_a = p2 - p0;
    assign coef_b = (p0 <<< 1) - (p1 <<< 2) - p1 + (p2 <<< 2) - p3;
    assign coef_c = p3 - p0 + (p1 <<< 1) + p1 - (p2 <<< 1) - p2;

    // Product by t, rounded half up back to Q16.16.
    assign prod_rnd = prod + PROD_W'(1 << (FRAC_BITS - 1));
    assign h_scaled = HORNER_W'(prod_rnd >>> FRAC_BITS);

    always_comb begin
      unique case (cmd.term)
        TERM_B:  addend = kb;
        TERM_A:  addend = ka;
        default: addend = '0;
      endcase
    end

    assign fin_sum  = (FIN_W'(p1) <<< 1) + FIN_W'(acc) + FIN_W'(1);
    assign fin_half = fin_sum >>> 1;

    always_comb begin
      if (fin_half[FIN_W-1:COORD_W-1] == '0 || fin_half[FIN_W-1:COORD_W-1] == '1) begin
        fin_sat = fin_half[COORD_W-1:0];
      end else if (fin_half[FIN_W-1]) begin
        fin_sat = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
        fin_sat = {1'b0, {(COORD_W-1){1'b1}}};
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.coef) begin
        acc <= coef_c;
        ka  <= coef_a;
        kb  <= coef_b;
      end else if (cmd.add) begin
        acc <= h_scaled + addend;
      end
      if (cmd.mul) begin
        prod <= acc * t_mul;
      end
      if (cmd.push) begin
        lane_res[l] <= fin_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      segment  <= seg;
      fraction <= t_val;
      at_end   <= end_flag;
    end
  end

  assign pos_x = lane_res[0];
  assign pos_y = lane_res[1];
  assign pos_z = lane_res[2];

endmodule

`default_nettype wire

### hdl/catmull_rom_path_follower_core.sv
// Uniform Catmull-Rom path follower over a table of 3D control points in Q16.16.
// Input channel item_in: action 0 loads point_x/y/z into slot point_index and gives
// no result; action 1 is a tick that yields one beat on result_out with the position,
// the segment in use, the fraction t (Q1.16) and the end flag.
// A load writes its point into the table at its accepting edge. A tick runs from
// its accepting edge to the result register in this order: the frame-count divider
// resolves two quotient bits a cycle while the single point-memory read port fetches
// the four control points, the coefficients are formed, then three multiply and
// accumulate pairs run over the three axes in parallel, and a final halving and
// saturation follow. No item is taken during a tick; after a load, one every cycle.
// The result sits in an output register, so the block accepts further items while
// a result waits; a tick that finishes while the receiver still stalls waits in
// its last step until the register frees.
// Configuration is written through cfg_wr_en, cfg_index and cfg_data by the user
// while idle; the block itself does not enforce this. Reset sets frames_per_segment
// to 60, point_count to 4, the segment to 1 and the frame count to 0. The point
// table is not cleared: load every slot that the path reads before the first tick.
`default_nettype none

module catmull_rom_path_follower_core #(
  parameter int MAX_POINTS = crpf_pkg::MAX_POINTS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wr_en,
  input  wire logic [crpf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [crpf_pkg::CFG_DATA_W-1:0] cfg_data,
  crpf_in_if.sink                              item_in,
  crpf_out_if.source                           result_out
);
  import crpf_pkg::*;

  cmd_t cmd;

  crpf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item_in.valid),
    .in_action (item_in.action),
    .out_ready (result_out.ready),
    .in_ready  (item_in.ready),
    .out_valid (result_out.valid),
    .cmd       (cmd)
  );

  crpf_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .point_index (item_in.point_index),
    .point_x     (item_in.point_x),
    .point_y     (item_in.point_y),
    .point_z     (item_in.point_z),
    .pos_x       (result_out.pos_x),
    .pos_y       (result_out.pos_y),
    .pos_z       (result_out.pos_z),
    .segment     (result_out.segment),
    .fraction    (result_out.fraction),
    .at_end      (result_out.at_end)
  );

endmodule

`default_nettype wire

### hdl/crpf_assert.sv
`default_nettype none
`include "catmull_rom_path_follower_core_defines.svh"

module crpf_assert (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic signed [crpf_pkg::COORD_W-1:0] pos_x,
  input wire logic signed [crpf_pkg::COORD_W-1:0] pos_y,
  input wire logic signed [crpf_pkg::COORD_W-1:0] pos_z,
  input wire logic [crpf_pkg::SEG_W-1:0]          segment,
  input wire logic [crpf_pkg::FRAC_W-1:0]         fraction,
  input wire logic                                at_end
);
  import crpf_pkg::*;

  logic [3*COORD_W+SEG_W+FRAC_W:0] payload;

  assign payload = {pos_x, pos_y, pos_z, segment, fraction, at_end};

  // A stalled beat keeps its contents.
  `CRPF_ASSERT(a_hold_payload, clk, rst, out_valid && !out_ready |=> $stable(payload), "result beat changed while stalled")
  // The fraction reaches one exactly when the path end is held.
  `CRPF_ASSERT(a_end_full_t, clk, rst, out_valid |-> (at_end == (fraction == T_ONE)), "end flag disagrees with fraction")
  // The segment in use never drops below the first real one.
  `CRPF_ASSERT(a_segment_nonzero, clk, rst, out_valid |-> (segment != '0), "segment zero reported")
  `CRPF_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !out_valid, "result valid after reset")

endmodule

bind catmull_rom_path_follower_core crpf_assert u_crpf_assert (
  .clk       (clk),
  .rst       (rst),
  .out_valid (result_out.valid),
  .out_ready (result_out.ready),
  .pos_x     (result_out.pos_x),
  .pos_y     (result_out.pos_y),
  .pos_z     (result_out.pos_z),
  .segment   (result_out.segment),
  .fraction  (result_out.fraction),
  .at_end    (result_out.at_end)
);

`default_nettype wire
